### src/two_tap_feedback_echo_assert.svh
// Assertion macros used by the checker of the two-tap feedback echo.
`ifndef TWO_TAP_FEEDBACK_ECHO_ASSERT_SVH
`define TWO_TAP_FEEDBACK_ECHO_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tfe_pkg.sv
// Package with the fixed constants and register codes of the two-tap feedback echo.
package tfe_pkg;

    localparam int HISTORY_DEPTH = 4096;
    localparam int POS_W         = 12;
    localparam int MAX_CHANNELS  = 2;
    localparam int CHAN_W        = 1;
    localparam int CNT_W         = 2;
    localparam int GAIN_W        = 16;
    localparam int DELAY_W       = 12;
    localparam int GAIN_FRAC     = 12;
    localparam int FRAC_SHIFT    = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic [DELAY_W-1:0]       delay_t;

    localparam gain_t SEVEN_TENTHS_Q12 = 16'sd2867;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd5;

    // Values after reset.
    localparam gain_t            RST_INPUT_GAIN    = 16'sd4096;
    localparam gain_t            RST_ECHO_GAIN     = 16'sd1638;
    localparam delay_t           RST_FIRST_DELAY   = 12'd1102;
    localparam delay_t           RST_SECOND_DELAY  = 12'd1190;
    localparam logic             RST_INVERT_SECOND = 1'b0;
    localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 2'd2;

endpackage

### src/tfe_in_if.sv
// Input stream interface: one audio sample and its channel per transaction.
interface tfe_in_if #(
    parameter int SAMPLE_BITS = 16
);
    import tfe_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [CHAN_W-1:0]             channel_index;

    modport source (output valid, output sample_in, output channel_index, input ready);
    modport sink   (input valid, input sample_in, input channel_index, output ready);
endinterface

### src/tfe_out_if.sv
// Output stream interface: one echoed sample and its clip flag per transaction.
interface tfe_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

### src/two_tap_feedback_echo.sv
// Two-tap feedback echo: top level with sequencer, shared multiplier and history RAM.
//
// Samples arrive on in_ch, interleaved by channel, and each one yields exactly one
// transaction on out_ch: y = input_gain*x + echo_gain*y1 +/- 0.7*echo_gain*y2, where
// y1 and y2 are this block's own earlier outputs first_delay and second_delay frames
// back in the same channel. Gains are signed Q3.12; the result is truncated toward
// zero and saturated to the sample range, with clipped flagging saturation.
// Write registers on the cfg_write/cfg_index/cfg_data port only while idle; the
// block itself does not enforce this. Each sample passes through six steps of a
// single shared multiplier and accumulator, then the idle step, before the next
// accept; two of the steps wait on the registered read port of the history RAM.
// The result is valid once the final step completes. A finished result sits in an
// output register, so the next sample is accepted while it waits; if the receiver
// stalls longer, the sequencer holds in its final step and does not write the history.
// After reset the block clears its 8192-entry history RAM, one entry a cycle,
// and accepts no sample until the clearing pass is done; configuration writes are
// taken throughout. Reset also restores the register defaults and frame position zero.
module two_tap_feedback_echo #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tfe_in_if.sink                             in_ch,
    tfe_out_if.source                          out_ch,
    input  logic                               cfg_write,
    input  logic [tfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfe_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tfe_pkg::*;

    // Width of a multiplier operand that can hold a sample or a gain times a sample.
    localparam int B_W    = SAMPLE_BITS + GAIN_W;
    localparam int PROD_W = GAIN_W + B_W;
    // The full Q24 sum stays below 2^(SAMPLE_BITS+28) in magnitude.
    localparam int ACC_W  = SAMPLE_BITS + 29;
    localparam int Q_W    = ACC_W - FRAC_SHIFT;
    localparam int ADDR_W = CHAN_W + POS_W;
    localparam int DEPTH  = MAX_CHANNELS * HISTORY_DEPTH;

    localparam logic signed [Q_W-1:0] Q_MAX =
        Q_W'(signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
    localparam logic signed [Q_W-1:0] Q_MIN = ~Q_MAX;
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((1 << FRAC_SHIFT) - 1);

    // Sequencer steps.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAP1  = 3'd1;
    localparam logic [2:0] S_TAP2  = 3'd2;
    localparam logic [2:0] S_TAP3  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    // Configuration registers.
    gain_t            ig_reg;
    gain_t            eg_reg;
    delay_t           d1_reg;
    delay_t           d2_reg;
    logic             inv_reg;
    logic [CNT_W-1:0] cc_reg;

    // Control state.
    logic [2:0]        state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers.
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CHAN_W-1:0]             chan_reg;
    logic                          adv_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] sout_reg;
    logic                          clip_reg;

    logic              in_fire;
    logic              fin_fire;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  last_chan;
    logic [POS_W-1:0]  tap1_pos;
    logic [POS_W-1:0]  tap2_pos;

    logic signed [GAIN_W-1:0] mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  prod_term;

    logic signed [ACC_W-1:0]       acc_adj;
    logic signed [Q_W-1:0]         q_full;
    logic signed [SAMPLE_BITS-1:0] q_sat;
    logic                          q_clip;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // Handshakes. A sample is taken only in the idle step once the clearing pass is done.
    assign in_ch.ready = (state_reg == S_IDLE) && !clearing_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign fin_fire    = (state_reg == S_FIN) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sout_reg;
    assign out_ch.clipped    = clip_reg;

    // A channel count of zero acts as one channel; counts above the ring's channels saturate.
    always_comb
    begin
        if (cc_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (cc_reg > CNT_W'(MAX_CHANNELS))
        begin
            eff_count = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            eff_count = cc_reg;
        end
        last_chan = eff_count - CNT_W'(1);
    end

    // The ring holds exactly 2^POS_W frames, so subtracting the delay wraps on its own.
    // A delay of zero reads the current slot before this sample overwrites it.
    assign tap1_pos = pos_reg - POS_W'(d1_reg);
    assign tap2_pos = pos_reg - POS_W'(d2_reg);

    // The one shared multiplier: its operands follow the sequencer step.
    always_comb
    begin
        mul_a = ig_reg;
        mul_b = B_W'(x_reg);
        case (state_reg)
            S_TAP1:
            begin
                mul_a = ig_reg;
                mul_b = B_W'(x_reg);
            end
            S_TAP2, S_TAP3:
            begin
                mul_a = eg_reg;
                mul_b = B_W'(signed'(ram_rdata));
            end
            S_SCALE:
            begin
                mul_a = SEVEN_TENTHS_Q12;
                mul_b = signed'(prod_reg[B_W-1:0]);
            end
            default:
            begin
                mul_a = ig_reg;
                mul_b = B_W'(x_reg);
            end
        endcase
    end

    assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_term = signed'(prod_reg[ACC_W-1:0]);

    // Accumulator: the two Q12 products are lifted to Q24, the scaled second tap is Q24.
    always_comb
    begin
        acc_next = acc_reg;
        case (state_reg)
            S_TAP2:
            begin
                acc_next = prod_term <<< GAIN_FRAC;
            end
            S_TAP3:
            begin
                acc_next = acc_reg + (prod_term <<< GAIN_FRAC);
            end
            S_SUM:
            begin
                if (inv_reg)
                begin
                    acc_next = acc_reg - prod_term;
                end
                else
                begin
                    acc_next = acc_reg + prod_term;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Divide by 2^24 rounding toward zero, then saturate to the sample range.
    always_comb
    begin
        acc_adj = acc_reg[ACC_W-1] ? (acc_reg + RND_BIAS) : acc_reg;
        q_full  = Q_W'(acc_adj >>> FRAC_SHIFT);
        q_clip  = 1'b0;
        if (q_full > Q_MAX)
        begin
            q_sat  = Q_MAX[SAMPLE_BITS-1:0];
            q_clip = 1'b1;
        end
        else if (q_full < Q_MIN)
        begin
            q_sat  = Q_MIN[SAMPLE_BITS-1:0];
            q_clip = 1'b1;
        end
        else
        begin
            q_sat = q_full[SAMPLE_BITS-1:0];
        end
    end

    // History RAM: the clearing pass writes zeros, afterwards each result is stored
    // at its channel's slot of the current frame.
    always_comb
    begin
        ram_we    = clearing_reg || fin_fire;
        ram_waddr = clearing_reg ? clr_addr_reg : {chan_reg, pos_reg};
        ram_wdata = clearing_reg ? '0 : q_sat;
        ram_raddr = (state_reg == S_TAP2) ? {chan_reg, tap2_pos} : {chan_reg, tap1_pos};
    end

    tfe_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic of the sequencer, frame position and output valid.
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_TAP1;
                end
            end
            S_TAP1:  state_next = S_TAP2;
            S_TAP2:  state_next = S_TAP3;
            S_TAP3:  state_next = S_SCALE;
            S_SCALE: state_next = S_SUM;
            S_SUM:   state_next = S_FIN;
            S_FIN:
            begin
                if (fin_fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (adv_reg)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            ig_reg        <= RST_INPUT_GAIN;
            eg_reg        <= RST_ECHO_GAIN;
            d1_reg        <= RST_FIRST_DELAY;
            d2_reg        <= RST_SECOND_DELAY;
            inv_reg       <= RST_INVERT_SECOND;
            cc_reg        <= RST_CHANNEL_COUNT;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_INPUT_GAIN:    ig_reg  <= signed'(cfg_data[GAIN_W-1:0]);
                    REG_ECHO_GAIN:     eg_reg  <= signed'(cfg_data[GAIN_W-1:0]);
                    REG_FIRST_DELAY:   d1_reg  <= cfg_data[DELAY_W-1:0];
                    REG_SECOND_DELAY:  d2_reg  <= cfg_data[DELAY_W-1:0];
                    REG_INVERT_SECOND: inv_reg <= cfg_data[0];
                    REG_CHANNEL_COUNT: cc_reg  <= cfg_data[CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers. The frame advances after the last configured channel;
    // a sample of a channel at or above the count never advances it.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg    <= in_ch.sample_in;
            chan_reg <= in_ch.channel_index;
            adv_reg  <= (CNT_W'(in_ch.channel_index) == last_chan);
        end
        prod_reg <= mul_p;
        acc_reg  <= acc_next;
        if (fin_fire)
        begin
            sout_reg <= q_sat;
            clip_reg <= q_clip;
        end
    end
endmodule

### src/tfe_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module tfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/tfe_checker.sv
// Port-level checker of the two-tap feedback echo and its bind to the top level.
module tfe_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] sample_out,
    input logic                          clipped
);
`include "two_tap_feedback_echo_assert.svh"

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = ~S_MAX;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg, pending_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Samples taken but whose results have not yet been delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `TFE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready,
        "input accepted again right after a transaction")
    `TFE_ASSERT_NOW(a_no_invented_result, clk, rst_n, out_valid, pending_reg != 2'd0,
        "result shown with no sample outstanding")
    `TFE_ASSERT_NOW(a_clip_at_limit, clk, rst_n, out_valid && clipped,
        sample_out == S_MAX || sample_out == S_MIN, "clipped result not at a range limit")
    `TFE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(sample_out) && $stable(clipped), "stalled result changed")
endmodule

bind two_tap_feedback_echo tfe_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_tfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out),
    .clipped    (out_ch.clipped)
);

### tb/two_tap_feedback_echo_test.sv
// Self-checking testbench for the two-tap feedback echo: streamed samples against predicted echoes.
`timescale 1ns / 100ps

module two_tap_feedback_echo_test;
    import tfe_pkg::*;

    localparam int     SAMPLE_BITS     = 16;
    localparam int     HALF_PERIOD     = 5;
    localparam int     RESET_CYCLES    = 5;
    // Settling margin after the last echo; it lets the last history write
    // land before the registers are touched again.
    localparam int     SETTLE_CYCLES   = 12;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     ITEMS_PER_PHASE = 104;
    // A bound on the run time, ample for the history clear after reset plus
    // a worst-case stalled stream.
    localparam int     WATCHDOG_NS     = 5_000_000;
    localparam longint SAMPLE_MAX      = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN      = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CHAN_W-1:0]             chan;
    } audio_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } echo_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tfe_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    tfe_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

    two_tap_feedback_echo #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Samples waiting to be offered, and echoes predicted for accepted samples
    // that have not come out yet.
    audio_item_t  sample_backlog[$];
    echo_result_t pending_echoes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int failures;

    // Testbench copy of the register file. It only changes while the block is
    // idle, so the value here is the one the block uses for every sample.
    gain_t            dry_gain;
    gain_t            echo_gain;
    delay_t           first_delay;
    delay_t           second_delay;
    logic             invert_tap2;
    logic [CNT_W-1:0] channel_count;

    // Per-channel ring of past outputs and the current frame slot. The ring is
    // a power of two deep, so the position wraps by plain overflow.
    logic signed [SAMPLE_BITS-1:0] echo_history [MAX_CHANNELS][HISTORY_DEPTH];
    logic [POS_W-1:0]              frame_pos;

    always #HALF_PERIOD clk = ~clk;

    // Computes the echo of one accepted sample and advances the ring state.
    function automatic echo_result_t predict_echo(input logic signed [SAMPLE_BITS-1:0] x,
                                                  input logic [CHAN_W-1:0] chan);
        int               lanes;
        logic [POS_W-1:0] tap1_pos;
        logic [POS_W-1:0] tap2_pos;
        longint           y1;
        longint           y2;
        longint           acc;
        longint           q;
        echo_result_t     res;

        // A count of zero runs as one channel; a count above the channel
        // limit is clamped to it.
        if (channel_count == 0)
            lanes = 1;
        else if (channel_count > MAX_CHANNELS)
            lanes = MAX_CHANNELS;
        else
            lanes = channel_count;

        // A delay of zero lands on the current slot before it is overwritten,
        // which still holds the output of one full ring revolution ago.
        tap1_pos = frame_pos - first_delay;
        tap2_pos = frame_pos - second_delay;
        y1 = longint'(echo_history[chan][tap1_pos]);
        y2 = longint'(echo_history[chan][tap2_pos]);

        // Dry and first tap in Q12, scaled up to Q24 to line up with the
        // second tap, whose 0.7 factor adds another twelve fraction bits.
        acc = (longint'(dry_gain) * longint'(x) + longint'(echo_gain) * y1) <<< GAIN_FRAC;
        if (invert_tap2)
            acc = acc - longint'(SEVEN_TENTHS_Q12) * longint'(echo_gain) * y2;
        else
            acc = acc + longint'(SEVEN_TENTHS_Q12) * longint'(echo_gain) * y2;

        // Signed division truncates toward zero, unlike an arithmetic shift.
        q = acc / (longint'(1) <<< FRAC_SHIFT);
        res.clipped = 1'b0;
        if (q > SAMPLE_MAX)
        begin
            q = SAMPLE_MAX;
            res.clipped = 1'b1;
        end
        if (q < SAMPLE_MIN)
        begin
            q = SAMPLE_MIN;
            res.clipped = 1'b1;
        end
        res.sample = q[SAMPLE_BITS-1:0];

        // The saturated output feeds back. The frame moves on only after the
        // last channel of the frame; channels at or above the count still use
        // their own ring but leave the position alone.
        echo_history[chan][frame_pos] = res.sample;
        if (int'(chan) == lanes - 1)
            frame_pos = frame_pos + 1'b1;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_BITS'(SAMPLE_MAX);
            1:       return SAMPLE_BITS'(SAMPLE_MIN);
            2:       return '0;
            3:       return SAMPLE_BITS'($urandom_range(64)) - SAMPLE_BITS'(32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly moderate gains so that the feedback neither dies out nor pins
    // the output at the rails, with the extremes mixed in.
    function automatic logic [CFG_DATA_W-1:0] random_gain(input int span);
        case ($urandom_range(9))
            0:       return CFG_DATA_W'(16'h7FFF);
            1:       return CFG_DATA_W'(16'h8000);
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(2 * span) - span);
        endcase
    endfunction

    // Short delays make the echoes show up within one phase; long ones reach
    // back into earlier phases or into slots never written since reset.
    function automatic logic [CFG_DATA_W-1:0] random_delay();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'({DELAY_W{1'b1}});
            2:       return CFG_DATA_W'($urandom_range({DELAY_W{1'b1}}));
            3, 4:    return CFG_DATA_W'($urandom_range(300, 25));
            default: return CFG_DATA_W'($urandom_range(24, 1));
        endcase
    endfunction

    // One register write on the configuration port, mirrored in the local copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_INPUT_GAIN:    dry_gain      = gain_t'(value);
            REG_ECHO_GAIN:     echo_gain     = gain_t'(value);
            REG_FIRST_DELAY:   first_delay   = value[DELAY_W-1:0];
            REG_SECOND_DELAY:  second_delay  = value[DELAY_W-1:0];
            REG_INVERT_SECOND: invert_tap2   = value[0];
            REG_CHANNEL_COUNT: channel_count = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Returns once every queued sample has been taken and echoed, and the
    // block has had time to finish its history write. The queues and the
    // valid line are looked at on the falling edge, when the driver's and
    // the monitor's updates from the rising edge have all settled.
    task automatic wait_idle();
        while (sample_backlog.size() != 0 || in_ch.valid || pending_echoes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input longint value, input int chan);
        audio_item_t item;
        item.sample = SAMPLE_BITS'(value);
        item.chan   = CHAN_W'(chan);
        sample_backlog.push_back(item);
    endtask

    // Driver. A transaction that completes on this edge is predicted right
    // away; the next sample is offered once the current one is gone, unless
    // the sender decides to sit idle for this cycle.
    always @(posedge clk or negedge rst_n)
    begin : driver
        audio_item_t item;
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.sample_in     <= '0;
            in_ch.channel_index <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                pending_echoes.push_back(predict_echo(in_ch.sample_in, in_ch.channel_index));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item = sample_backlog.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.sample_in     <= item.sample;
                    in_ch.channel_index <= item.chan;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every completed output transaction is matched against the
    // oldest predicted echo; ready is redrawn on every cycle.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        echo_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_echoes.size() == 0)
                begin
                    $error("unexpected output transaction: sample_out %0d clipped %0b",
                           $signed(out_ch.sample_out), out_ch.clipped);
                    failures++;
                end
                else
                begin
                    want = pending_echoes.pop_front();
                    if (out_ch.sample_out !== want.sample)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(want.sample), $signed(out_ch.sample_out));
                        failures++;
                    end
                    if (out_ch.clipped !== want.clipped)
                    begin
                        $error("clipped: expected %0b, actual %0b", want.clipped, out_ch.clipped);
                        failures++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int lanes;
        int lane;
        int chan;
        logic [CFG_DATA_W-1:0] count_value;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.sample_in     = '0;
        in_ch.channel_index = '0;
        out_ch.ready        = 1'b0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        failures            = 0;

        dry_gain      = RST_INPUT_GAIN;
        echo_gain     = RST_ECHO_GAIN;
        first_delay   = RST_FIRST_DELAY;
        second_delay  = RST_SECOND_DELAY;
        invert_tap2   = RST_INVERT_SECOND;
        channel_count = RST_CHANNEL_COUNT;
        frame_pos     = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
            for (int p = 0; p < HISTORY_DEPTH; p++)
                echo_history[c][p] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block clears its history before it takes the
        // first sample, so these simply wait in the backlog.
        // Register defaults: unity dry gain, echoes far beyond this stretch.
        queue_sample(SAMPLE_MAX, 0);
        queue_sample(SAMPLE_MIN, 1);
        queue_sample(0, 0);
        queue_sample(-1, 1);
        wait_idle();

        // Largest dry gain against the most negative echo gain, a one-frame
        // first tap, a zero-delay second tap, and the second tap negated.
        write_reg(REG_INPUT_GAIN,    CFG_DATA_W'(16'h7FFF));
        write_reg(REG_ECHO_GAIN,     CFG_DATA_W'(16'h8000));
        write_reg(REG_FIRST_DELAY,   CFG_DATA_W'(1));
        write_reg(REG_SECOND_DELAY,  CFG_DATA_W'(0));
        write_reg(REG_INVERT_SECOND, CFG_DATA_W'(1));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(2));
        queue_sample(SAMPLE_MAX, 0);
        queue_sample(SAMPLE_MIN, 1);
        queue_sample(SAMPLE_MIN, 0);
        queue_sample(SAMPLE_MAX, 1);
        queue_sample(1, 0);
        queue_sample(-1, 1);
        queue_sample(0, 0);
        queue_sample(0, 1);
        wait_idle();

        // Channel count zero runs as a single channel: samples tagged for
        // channel one are filtered but never advance the frame.
        write_reg(REG_INPUT_GAIN,    CFG_DATA_W'(16'h8000));
        write_reg(REG_ECHO_GAIN,     CFG_DATA_W'(16'h7FFF));
        write_reg(REG_FIRST_DELAY,   CFG_DATA_W'({DELAY_W{1'b1}}));
        write_reg(REG_SECOND_DELAY,  CFG_DATA_W'(2));
        write_reg(REG_INVERT_SECOND, CFG_DATA_W'(0));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(0));
        queue_sample(SAMPLE_MAX, 0);
        queue_sample(100, 1);
        queue_sample(SAMPLE_MIN, 0);
        queue_sample(-1, 1);
        queue_sample(0, 0);
        queue_sample(1, 1);
        wait_idle();

        // A count above the channel limit is clamped to two channels.
        write_reg(REG_INPUT_GAIN,    CFG_DATA_W'(RST_INPUT_GAIN));
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(3));
        queue_sample(1234, 0);
        queue_sample(-1234, 1);
        queue_sample(SAMPLE_MAX, 1);
        queue_sample(SAMPLE_MIN, 0);
        wait_idle();

        // Random part. Each phase draws a fresh register setting and runs one
        // of the idling patterns. Samples mostly follow the channel order of
        // the frame, with a stray channel now and then.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase

            case ($urandom_range(9))
                0:       count_value = CFG_DATA_W'(0);
                1:       count_value = CFG_DATA_W'(1);
                2:       count_value = CFG_DATA_W'(3);
                default: count_value = CFG_DATA_W'(2);
            endcase
            write_reg(REG_INPUT_GAIN,    random_gain(8192));
            write_reg(REG_ECHO_GAIN,     random_gain(2400));
            write_reg(REG_FIRST_DELAY,   random_delay());
            write_reg(REG_SECOND_DELAY,  random_delay());
            write_reg(REG_INVERT_SECOND, CFG_DATA_W'($urandom_range(1)));
            write_reg(REG_CHANNEL_COUNT, count_value);

            if (channel_count == 0)
                lanes = 1;
            else if (channel_count > MAX_CHANNELS)
                lanes = MAX_CHANNELS;
            else
                lanes = channel_count;

            lane = 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    chan = $urandom_range(MAX_CHANNELS - 1);
                end
                else
                begin
                    chan = lane;
                    lane = (lane + 1) % lanes;
                end
                queue_sample(random_sample(), chan);
            end
            wait_idle();
        end

        if (failures == 0 && pending_echoes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/tfe_pkg.sv
src/tfe_in_if.sv
src/tfe_out_if.sv
src/tfe_ram.sv
src/two_tap_feedback_echo.sv
src/tfe_checker.sv
tb/two_tap_feedback_echo_test.sv
